// ===== hdl/lcr_pkg.sv =====
// Shared types and constants for the clipped line rasterizer.
package lcr_pkg;

  localparam int unsigned COORD_W     = 16;
  localparam int unsigned DELTA_W     = COORD_W + 1;
  localparam int unsigned ERR_W       = COORD_W + 3;
  localparam int unsigned DIM_W       = 13;
  localparam int unsigned PITCH_W     = 14;
  localparam int unsigned INDEX_W     = 25;
  localparam int unsigned COLOR_W     = 32;
  localparam int unsigned CFG_DATA_W  = 14;
  localparam int unsigned CFG_INDEX_W = 2;

  // Clip limit for width and height
  localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

  // Operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SURFACE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SURFACE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_PITCH      = 2'd2;

  // Register reset values
  localparam logic [DIM_W-1:0]   RST_SURFACE_WIDTH  = 13'd1024;
  localparam logic [DIM_W-1:0]   RST_SURFACE_HEIGHT = 13'd768;
  localparam logic [PITCH_W-1:0] RST_ROW_PITCH      = 14'd1024;

  typedef struct packed {
    logic [DIM_W-1:0]   surface_width;
    logic [DIM_W-1:0]   surface_height;
    logic [PITCH_W-1:0] row_pitch;
  } cfg_t;

  typedef struct packed {
    logic                      op;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] finish_x;
    logic signed [COORD_W-1:0] finish_y;
    logic [COLOR_W-1:0]        color;
  } item_t;

  typedef struct packed {
    logic               write_enable;
    logic [INDEX_W-1:0] pixel_index;
    logic [COLOR_W-1:0] pixel_value;
    logic               last;
  } pixel_t;

endpackage

// ===== hdl/lcr_if.sv =====
// Request channel interfaces: line commands in, pixel writes out.
interface lcr_in_if;
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic signed [lcr_pkg::COORD_W-1:0] start_x;
  logic signed [lcr_pkg::COORD_W-1:0] start_y;
  logic signed [lcr_pkg::COORD_W-1:0] finish_x;
  logic signed [lcr_pkg::COORD_W-1:0] finish_y;
  logic [lcr_pkg::COLOR_W-1:0]        color;

  modport source (output valid, op, start_x, start_y, finish_x, finish_y, color,
                  input ready);
  modport sink   (input valid, op, start_x, start_y, finish_x, finish_y, color,
                  output ready);
endinterface

interface lcr_out_if;
  logic                         valid;
  logic                         ready;
  logic                         write_enable;
  logic [lcr_pkg::INDEX_W-1:0]  pixel_index;
  logic [lcr_pkg::COLOR_W-1:0]  pixel_value;
  logic                         last;

  modport source (output valid, write_enable, pixel_index, pixel_value, last,
                  input ready);
  modport sink   (input valid, write_enable, pixel_index, pixel_value, last,
                  output ready);
endinterface

// ===== hdl/clipped_line_rasterizer.sv =====
// A request is registered into the engine stage on acceptance; a step's pixel
// enters the output register when the engine takes it, which a stalled output
// can delay. Throughput: one request per cycle unless the output stalls; each
// step is one error update plus one 12x14 multiply-add for the pixel index, all
// within the engine stage. Reset (synchronous, rst_n low): no line active, both
// stages empty, surface registers back to 1024 x 768 with pitch 1024.
module clipped_line_rasterizer (
  input  logic                            clk,
  input  logic                            rst_n,
  lcr_in_if.sink                          in_chan,
  lcr_out_if.source                       out_chan,
  input  logic                            cfg_we,
  input  logic [lcr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [lcr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  lcr_pkg::cfg_t   cfg;
  lcr_pkg::item_t  in_item;
  lcr_pkg::item_t  s1_item_r;
  lcr_pkg::pixel_t eng_result;
  lcr_pkg::pixel_t out_pix_r;
  logic            s1_valid_r, s1_valid_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            advance, take, in_fire, eng_has_result;

  lcr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Gather the request fields
  always_comb begin
    in_item.op       = in_chan.op;
    in_item.start_x  = in_chan.start_x;
    in_item.start_y  = in_chan.start_y;
    in_item.finish_x = in_chan.finish_x;
    in_item.finish_y = in_chan.finish_y;
    in_item.color    = in_chan.color;
  end

  // Stage handshake: the engine consumes when the output register can take a pixel
  assign advance        = !out_valid_r || out_chan.ready;
  assign take           = s1_valid_r && advance;
  assign in_chan.ready  = !s1_valid_r || advance;
  assign in_fire        = in_chan.valid && in_chan.ready;

  always_comb begin
    s1_valid_nxt = in_fire ? 1'b1 : (take ? 1'b0 : s1_valid_r);
    out_valid_nxt = advance ? (take && eng_has_result) : out_valid_r;
  end

  lcr_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .item       (s1_item_r),
    .cfg        (cfg),
    .has_result (eng_has_result),
    .result     (eng_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the request and the pixel payloads
  always_ff @(posedge clk) begin
    if (in_fire) s1_item_r <= in_item;
    if (take && eng_has_result) out_pix_r <= eng_result;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.write_enable = out_pix_r.write_enable;
  assign out_chan.pixel_index  = out_pix_r.pixel_index;
  assign out_chan.pixel_value  = out_pix_r.pixel_value;
  assign out_chan.last         = out_pix_r.last;

  // A full input stage behind a stalled output refuses new requests
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_chan.ready) |-> !in_chan.ready)
    else $error("request accepted into a blocked stage");

endmodule

// ===== hdl/lcr_cfg_regs.sv =====
// Surface configuration registers with a plain write port.
module lcr_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lcr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lcr_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output lcr_pkg::cfg_t                     cfg
);

  lcr_pkg::cfg_t cfg_r, cfg_nxt;

  // Decode the write; unknown indexes are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        lcr_pkg::REG_SURFACE_WIDTH:  cfg_nxt.surface_width  = cfg_wdata[lcr_pkg::DIM_W-1:0];
        lcr_pkg::REG_SURFACE_HEIGHT: cfg_nxt.surface_height = cfg_wdata[lcr_pkg::DIM_W-1:0];
        lcr_pkg::REG_ROW_PITCH:      cfg_nxt.row_pitch      = cfg_wdata[lcr_pkg::PITCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.surface_width  <= lcr_pkg::RST_SURFACE_WIDTH;
      cfg_r.surface_height <= lcr_pkg::RST_SURFACE_HEIGHT;
      cfg_r.row_pitch      <= lcr_pkg::RST_ROW_PITCH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

  // A pitch write lands on the next edge
  a_pitch_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_index == lcr_pkg::REG_ROW_PITCH) |=>
      cfg_r.row_pitch == $past(cfg_wdata[lcr_pkg::PITCH_W-1:0]))
    else $error("row pitch write lost");

endmodule

// ===== hdl/lcr_engine.sv =====
// Bresenham line state, one step per consumed step request, and pixel clip/index.
module lcr_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  lcr_pkg::item_t  item,
  input  lcr_pkg::cfg_t   cfg,
  output logic            has_result,
  output lcr_pkg::pixel_t result
);

  localparam int unsigned CW = lcr_pkg::COORD_W;
  localparam int unsigned DW = lcr_pkg::DELTA_W;
  localparam int unsigned EW = lcr_pkg::ERR_W;

  logic                  active_r, active_nxt;
  logic signed [CW-1:0]  cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic signed [CW-1:0]  end_x_r, end_x_nxt, end_y_r, end_y_nxt;
  logic [DW-1:0]         delta_x_r, delta_x_nxt, delta_y_r, delta_y_nxt;
  logic                  step_neg_x_r, step_neg_x_nxt, step_neg_y_r, step_neg_y_nxt;
  logic signed [EW-1:0]  error_r, error_nxt;
  logic [lcr_pkg::COLOR_W-1:0] color_r, color_nxt;

  // Start set-up
  logic signed [DW-1:0]  diff_x, diff_y;
  logic [DW-1:0]         abs_x, abs_y;

  // Step decision
  logic signed [EW:0]    e2, neg_dy, pos_dx;
  logic                  move_x, move_y, at_end;

  // Clip and index
  logic [lcr_pkg::DIM_W-1:0] w_clip, h_clip;
  logic                      in_view;
  logic [lcr_pkg::INDEX_W:0] prod, lin;

  // Absolute deltas of the new line
  always_comb begin
    diff_x = DW'(item.finish_x) - DW'(item.start_x);
    diff_y = DW'(item.finish_y) - DW'(item.start_y);
    abs_x  = diff_x[DW-1] ? DW'(-diff_x) : DW'(diff_x);
    abs_y  = diff_y[DW-1] ? DW'(-diff_y) : DW'(diff_y);
  end

  // Error test against the current error
  always_comb begin
    e2     = {error_r, 1'b0};
    neg_dy = -$signed({3'b000, delta_y_r});
    pos_dx = $signed({3'b000, delta_x_r});
    move_x = e2 > neg_dy;
    move_y = e2 < pos_dx;
    at_end = (cur_x_r == end_x_r) && (cur_y_r == end_y_r);
  end

  // Clip to the surface and form y*pitch+x
  always_comb begin
    w_clip = (cfg.surface_width  > lcr_pkg::MAX_DIM) ? lcr_pkg::MAX_DIM : cfg.surface_width;
    h_clip = (cfg.surface_height > lcr_pkg::MAX_DIM) ? lcr_pkg::MAX_DIM : cfg.surface_height;
    in_view = !cur_x_r[CW-1] && !cur_y_r[CW-1]
              && ({{(CW-1-lcr_pkg::DIM_W){1'b0}}, w_clip} > cur_x_r[CW-2:0])
              && ({{(CW-1-lcr_pkg::DIM_W){1'b0}}, h_clip} > cur_y_r[CW-2:0]);
    prod   = (lcr_pkg::INDEX_W+1)'(cur_y_r[11:0]) * (lcr_pkg::INDEX_W+1)'(cfg.row_pitch);
    lin    = prod + (lcr_pkg::INDEX_W+1)'(cur_x_r[11:0]);
  end

  // Next state and result
  always_comb begin
    active_nxt     = active_r;
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    end_x_nxt      = end_x_r;
    end_y_nxt      = end_y_r;
    delta_x_nxt    = delta_x_r;
    delta_y_nxt    = delta_y_r;
    step_neg_x_nxt = step_neg_x_r;
    step_neg_y_nxt = step_neg_y_r;
    error_nxt      = error_r;
    color_nxt      = color_r;
    has_result     = 1'b0;

    result.write_enable = in_view;
    result.pixel_index  = in_view ? lin[lcr_pkg::INDEX_W-1:0] : '0;
    result.pixel_value  = color_r;
    result.last         = at_end;

    if (take) begin
      if (item.op == lcr_pkg::OP_START) begin
        // Load a new line, dropping any line in progress
        active_nxt     = 1'b1;
        cur_x_nxt      = item.start_x;
        cur_y_nxt      = item.start_y;
        end_x_nxt      = item.finish_x;
        end_y_nxt      = item.finish_y;
        delta_x_nxt    = abs_x;
        delta_y_nxt    = abs_y;
        step_neg_x_nxt = !(item.start_x < item.finish_x);
        step_neg_y_nxt = !(item.start_y < item.finish_y);
        error_nxt      = EW'({2'b00, abs_x}) - EW'({2'b00, abs_y});
        color_nxt      = item.color;
      end else if (active_r) begin
        has_result = 1'b1;
        if (at_end) begin
          active_nxt = 1'b0;
        end else begin
          // Advance error and position
          error_nxt = error_r
                      - (move_x ? EW'({2'b00, delta_y_r}) : '0)
                      + (move_y ? EW'({2'b00, delta_x_r}) : '0);
          if (move_x) cur_x_nxt = step_neg_x_r ? cur_x_r - CW'(1) : cur_x_r + CW'(1);
          if (move_y) cur_y_nxt = step_neg_y_r ? cur_y_r - CW'(1) : cur_y_r + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r      <= cur_x_nxt;
    cur_y_r      <= cur_y_nxt;
    end_x_r      <= end_x_nxt;
    end_y_r      <= end_y_nxt;
    delta_x_r    <= delta_x_nxt;
    delta_y_r    <= delta_y_nxt;
    step_neg_x_r <= step_neg_x_nxt;
    step_neg_y_r <= step_neg_y_nxt;
    error_r      <= error_nxt;
    color_r      <= color_nxt;
  end

  // The endpoint pixel ends the line
  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (has_result && result.last) |=> !active_r)
    else $error("line still active after last pixel");

  // A clipped pixel carries a zero index
  a_clip_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
    (has_result && !result.write_enable) |-> result.pixel_index == '0)
    else $error("clipped pixel with nonzero index");

endmodule
